// ===== hdl/sslist_pkg.sv =====
// Shared types, constants and helpers for the sorted set list.
`default_nettype none
package sslist_pkg;

  localparam int CAPACITY    = 64;
  localparam int ELEM_WIDTH  = 32;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 6;
  localparam int COUNT_OUT_W = 7;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMP_W       = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int PC_W        = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GRP         = 8;
  localparam int NGRP        = (CAPACITY + GRP - 1) / GRP;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEEP_SORTED = 1'b0,
    REG_ALLOW_DUP   = 1'b1
  } cfg_reg_e;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                 cmp_en;
    logic                 add_en;
    logic                 rem_en;
    elem_t                value;
    logic [POS_W-1:0]     pos;
    logic [CNT_W-1:0]     count;
  } cell_cmd_t;

  // per-cell compare results
  typedef struct packed {
    logic  ge;
    logic  eq;
    elem_t rd;
  } cell_flags_t;

  function automatic elem_t to_elem(input logic [VALUE_W-1:0] x);
    logic [ELEM_WIDTH+VALUE_W-1:0] tmp;
    tmp = {{ELEM_WIDTH{1'b0}}, x};
    return tmp[ELEM_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] from_elem(input elem_t e);
    logic [ELEM_WIDTH+VALUE_W-1:0] tmp;
    tmp = {{VALUE_W{1'b0}}, e};
    return tmp[VALUE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sslist_if.sv =====
// Valid/ready channel interfaces for command and result words.
`default_nettype none
interface sslist_in_if import sslist_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface sslist_out_if import sslist_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_W-1:0]     read_value;
  logic [1:0]             status;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output read_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/sslist_cell.sv =====
// One list slot: holds an entry, compares it, and shifts with its neighbors.
`default_nettype none
module sslist_cell import sslist_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire cell_cmd_t         cmd_i,
  input  wire logic              ins_i,
  input  wire logic              ins_prev_i,
  input  wire elem_t             prev_data_i,
  input  wire elem_t             next_data_i,
  output elem_t                  data_o,
  output cell_flags_t            flags_o
);

  elem_t       data_q;
  cell_flags_t flags_q;
  logic        valid;
  logic        sel;
  logic        at_or_after;

  assign valid       = CNT_W'(idx_i) < cmd_i.count;
  assign sel         = CMP_W'(idx_i) == CMP_W'(cmd_i.pos);
  assign at_or_after = CMP_W'(idx_i) >= CMP_W'(cmd_i.pos);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      flags_q.ge <= valid && (data_q >= cmd_i.value);
      flags_q.eq <= valid && (data_q == cmd_i.value);
      flags_q.rd <= (valid && sel) ? data_q : '0;
    end
    if (cmd_i.add_en) begin
      // first slot of the insert region takes the new word, the rest shift up
      if (ins_i) begin
        data_q <= ins_prev_i ? prev_data_i : cmd_i.value;
      end
    end else if (cmd_i.rem_en && at_or_after) begin
      data_q <= next_data_i;
    end
  end

  assign data_o  = data_q;
  assign flags_o = flags_q;

endmodule
`default_nettype wire

// ===== hdl/sslist_ctrl.sv =====
// Sequencer: takes a command word, reduces cell flags, drives the shift, emits the result.
`default_nettype none
module sslist_ctrl import sslist_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  sslist_in_if.sink                  in_i,
  sslist_out_if.source               out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire cell_flags_t           flags_i [CAPACITY],
  output cell_cmd_t                  cmd_o,
  output logic [CAPACITY-1:0]        ins_o
);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_RED, S_APPLY} state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       count_q;
  logic                   keep_sorted_q;
  logic                   allow_dup_q;
  logic                   out_valid_q;
  logic [VALUE_W-1:0]     out_rd_q;
  status_e                out_status_q;
  logic [COUNT_OUT_W-1:0] out_count_q;

  op_e                    op_q;
  elem_t                  v_q;
  logic [POS_W-1:0]       pos_q;
  logic [CAPACITY-1:0]    ins_q;
  logic                   eq_grp_q [NGRP];
  elem_t                  rd_grp_q [NGRP];

  logic [CAPACITY-1:0]    ge_vec;
  logic [CAPACITY-1:0]    pre;
  logic [CAPACITY-1:0]    beyond;
  logic [CAPACITY-1:0]    ins_d;
  logic                   eq_grp_d [NGRP];
  elem_t                  rd_grp_d [NGRP];

  logic                   any_eq;
  elem_t                  rd_all;
  logic                   pos_in;
  logic                   fire;
  status_e                res_status;
  logic [CNT_W-1:0]       res_count;
  elem_t                  res_rd;
  logic                   add_go;
  logic                   rem_go;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_vec
    assign ge_vec[i] = flags_i[i].ge;
    assign beyond[i] = CNT_W'(i) >= count_q;
  end

  // prefix OR: bit i set once any valid entry at or below i is >= the word
  always_comb begin
    pre = ge_vec;
    for (int s = 1; s < CAPACITY; s = s * 2) begin
      pre = pre | (pre << s);
    end
  end

  assign ins_d = keep_sorted_q ? (pre | beyond) : beyond;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      eq_grp_d[g] = 1'b0;
      rd_grp_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          eq_grp_d[g] = eq_grp_d[g] | flags_i[g*GRP+k].eq;
          rd_grp_d[g] = rd_grp_d[g] | flags_i[g*GRP+k].rd;
        end
      end
    end
  end

  always_comb begin
    any_eq = 1'b0;
    rd_all = '0;
    for (int g = 0; g < NGRP; g++) begin
      any_eq = any_eq | eq_grp_q[g];
      rd_all = rd_all | rd_grp_q[g];
    end
  end

  assign pos_in = PC_W'(pos_q) < PC_W'(count_q);

  always_comb begin
    res_status = ST_OK;
    res_count  = count_q;
    res_rd     = '0;
    add_go     = 1'b0;
    rem_go     = 1'b0;
    case (op_q)
      OP_ADD: begin
        if (!allow_dup_q && any_eq) begin
          res_status = ST_DUP;
        end else if (count_q == CNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          add_go    = 1'b1;
          res_count = count_q + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_in) begin
          rem_go    = 1'b1;
          res_count = count_q - 1'b1;
        end else begin
          res_status = ST_RANGE;
        end
      end
      OP_READ: begin
        if (pos_in) begin
          res_rd = rd_all;
        end else begin
          res_status = ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  assign fire = (state_q == S_APPLY) && (!out_valid_q || out_o.ready);

  assign cmd_o.cmp_en = state_q == S_CMP;
  assign cmd_o.add_en = fire && add_go;
  assign cmd_o.rem_en = fire && rem_go;
  assign cmd_o.value  = v_q;
  assign cmd_o.pos    = pos_q;
  assign cmd_o.count  = count_q;
  assign ins_o        = ins_q;

  assign in_i.ready        = state_q == S_IDLE;
  assign out_o.valid       = out_valid_q;
  assign out_o.read_value  = out_rd_q;
  assign out_o.status      = out_status_q;
  assign out_o.entry_count = out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      keep_sorted_q <= 1'b0;
      allow_dup_q   <= 1'b1;
      out_valid_q   <= 1'b0;
      out_rd_q      <= '0;
      out_status_q  <= ST_OK;
      out_count_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_KEEP_SORTED: keep_sorted_q <= cfg_data_i[0];
          REG_ALLOW_DUP:   allow_dup_q   <= cfg_data_i[0];
        endcase
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:  if (in_i.valid) state_q <= S_CMP;
        S_CMP:   state_q <= S_RED;
        S_RED:   state_q <= S_APPLY;
        S_APPLY: begin
          if (fire) begin
            state_q      <= S_IDLE;
            count_q      <= res_count;
            out_valid_q  <= 1'b1;
            out_rd_q     <= from_elem(res_rd);
            out_status_q <= res_status;
            out_count_q  <= COUNT_OUT_W'(res_count);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      op_q  <= op_e'(in_i.op);
      v_q   <= to_elem(in_i.value);
      pos_q <= in_i.position;
    end
    if (state_q == S_RED) begin
      ins_q <= ins_d;
      for (int g = 0; g < NGRP; g++) begin
        eq_grp_q[g] <= eq_grp_d[g];
        rd_grp_q[g] <= rd_grp_d[g];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sorted_set_list_top.sv =====
// Sorted set list: a row of compare-and-shift cells under a small sequencer.
// Each command passes through accept, cell compare, flag reduction and shift/apply,
// the compare-reduce-shift sequence through the cell row; a new command is taken
// only once the last one has left the apply step.
// A result stalled at the output holds the apply step, and with it the next command.
// Reset: count 0, keep_sorted 0, allow_duplicates 1; entries stay unwritten, no clearing pass.
`default_nettype none
module sorted_set_list_top import sslist_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  sslist_in_if.sink                  in_i,
  sslist_out_if.source               out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cell_cmd_t           cmd;
  cell_flags_t         flags [CAPACITY];
  elem_t               cell_data [CAPACITY];
  logic [CAPACITY-1:0] ins;

  sslist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .flags_i    (flags),
    .cmd_o      (cmd),
    .ins_o      (ins)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    elem_t prev_data;
    elem_t next_data;
    logic  ins_prev;

    if (i == 0) begin : g_first
      assign prev_data = '0;
      assign ins_prev  = 1'b0;
    end else begin : g_mid
      assign prev_data = cell_data[i-1];
      assign ins_prev  = ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_body
      assign next_data = cell_data[i+1];
    end

    sslist_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(i)),
      .cmd_i       (cmd),
      .ins_i       (ins[i]),
      .ins_prev_i  (ins_prev),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (cell_data[i]),
      .flags_o     (flags[i])
    );
  end

endmodule
`default_nettype wire

// ===== hdl/sslist_chk.sv =====
// Port-level assertions for the sorted set list, bound to the top level.
`default_nettype none
module sslist_chk import sslist_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic [VALUE_W-1:0]     read_value_i,
  input wire logic [1:0]             status_i,
  input wire logic [COUNT_OUT_W-1:0] entry_count_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_value_i)
      && $stable(status_i) && $stable(entry_count_i))
    else $error("result word changed while stalled");

  // one command in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command accepted while another is in flight");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> entry_count_i <= COUNT_OUT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_FULL |-> entry_count_i == COUNT_OUT_W'(CAPACITY))
    else $error("full status with list not full");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> read_value_i == '0)
    else $error("nonzero read value on error status");

endmodule

bind sorted_set_list_top sslist_chk u_sslist_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .read_value_i  (out_o.read_value),
  .status_i      (out_o.status),
  .entry_count_i (out_o.entry_count)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for sorted_set_list_top: a shadow list predicts every result word.
module testbench;
  import sslist_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_CMDS     = 216;

  typedef struct {
    logic [VALUE_W-1:0]     read_value;
    status_e                status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } list_result_t;

  // Shadow copy of the list; predicts one result word per accepted command.
  class list_shadow;
    elem_t        cells[CAPACITY];
    int           held;
    bit           sorted_mode;
    bit           dup_ok;
    list_result_t pending_results[$];
    int           errors;
    int           n_cmds;
    int           n_results;
    int           n_dup;
    int           n_full;
    int           n_range;

    function new();
      foreach (cells[i]) cells[i] = '0;
      held        = 0;
      sorted_mode = 1'b0;
      dup_ok      = 1'b1;
      errors      = 0;
      n_cmds      = 0;
      n_results   = 0;
      n_dup       = 0;
      n_full      = 0;
      n_range     = 0;
    endfunction

    function void set_mode(bit sorted, bit dups);
      sorted_mode = sorted;
      dup_ok      = dups;
    endfunction

    function status_e insert_word(elem_t v);
      int slot;
      // duplicate test spans every held entry and precedes the full test
      if (!dup_ok)
        for (int i = 0; i < held; i++)
          if (cells[i] == v) return ST_DUP;
      if (held >= CAPACITY) return ST_FULL;
      slot = held;
      if (sorted_mode)
        for (int i = 0; i < held; i++)
          if (cells[i] >= v) begin
            slot = i;
            break;
          end
      for (int i = held; i > slot; i--) cells[i] = cells[i-1];
      cells[slot] = v;
      held++;
      return ST_OK;
    endfunction

    function void take_command(op_e op, logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
      list_result_t r;
      r.read_value = '0;
      r.status     = ST_OK;
      case (op)
        OP_ADD: r.status = insert_word(value[ELEM_WIDTH-1:0]);
        OP_REMOVE: begin
          if (int'(pos) < held) begin
            for (int i = pos; i < held - 1; i++) cells[i] = cells[i+1];
            held--;
          end else begin
            r.status = ST_RANGE;
          end
        end
        OP_READ: begin
          if (int'(pos) < held) r.read_value = cells[pos];
          else r.status = ST_RANGE;
        end
        default: ;
      endcase
      r.entry_count = COUNT_OUT_W'(held);
      n_cmds++;
      if (r.status == ST_DUP) n_dup++;
      if (r.status == ST_FULL) n_full++;
      if (r.status == ST_RANGE) n_range++;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [VALUE_W-1:0] rd, logic [1:0] st,
                               logic [COUNT_OUT_W-1:0] cnt);
      list_result_t e;
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result word with no command outstanding");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (rd !== e.read_value) begin
        $error("read_value: expected %h, got %h", e.read_value, rd);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (cnt !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, cnt);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit   calm;
  int   quiet_cycles;
  int   rx_run;
  int   rx_stall;

  list_shadow shadow = new();

  sslist_in_if  cmd_if ();
  sslist_out_if res_if ();

  sorted_set_list_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (cmd_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // small values make duplicates likely; corners hit the compare extremes
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 15);
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if (shadow.held > 0 && $urandom_range(0, 99) < 75)
      return POS_W'($urandom_range(0, shadow.held - 1));
    return POS_W'($urandom_range(0, 63));
  endfunction

  task automatic issue_cmd(input op_e op, input logic [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      cmd_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_if.valid    <= 1'b1;
    cmd_if.op       <= op;
    cmd_if.value    <= value;
    cmd_if.position <= pos;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    shadow.take_command(op, value, pos);
  endtask

  // hold off commands until every result word is back, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (shadow.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(input bit sorted, input bit dups);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_KEEP_SORTED;
    cfg_data <= sorted;
    @(negedge clk);
    cfg_idx  <= REG_ALLOW_DUP;
    cfg_data <= dups;
    @(negedge clk);
    cfg_we   <= 1'b0;
    shadow.set_mode(sorted, dups);
  endtask

  // alternating fill and drain bursts so the list swings between empty and full
  task automatic run_phase(input int n_cmds);
    int   burst;
    int   r;
    bit   filling;
    op_e  op;
    filling = 1'b0;
    burst   = 0;
    for (int k = 0; k < n_cmds; k++) begin
      if (burst == 0) begin
        filling = ~filling;
        burst   = $urandom_range(40, 160);
      end
      burst--;
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_NOP;
      else if (r < (filling ? 80 : 35)) op = OP_ADD;
      else if (r < (filling ? 90 : 85)) op = OP_REMOVE;
      else op = OP_READ;
      issue_cmd(op, pick_value(), pick_pos());
    end
  endtask

  always begin
    @(negedge clk);
    res_if.ready <= 1'b1;
    rx_run = $urandom_range(0, 8);
    repeat (rx_run) @(negedge clk);
    rx_stall = pick_gap();
    if (rx_stall > 0) begin
      @(negedge clk);
      res_if.ready <= 1'b0;
      repeat (rx_stall - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (res_if.valid && res_if.ready)
        shadow.check_result(res_if.read_value, res_if.status, res_if.entry_count);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("** sorted_set_list_top: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    bit phase_sorted[NUM_PHASES];
    bit phase_dups[NUM_PHASES];
    phase_sorted = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    phase_dups   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    rst_n           = 1'b0;
    calm            = 1'b0;
    quiet_cycles    = 0;
    cmd_if.valid    = 1'b0;
    cmd_if.op       = OP_NOP;
    cmd_if.value    = '0;
    cmd_if.position = '0;
    res_if.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_KEEP_SORTED;
    cfg_data        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: append mode, duplicates allowed
    issue_cmd(OP_READ,   32'h0,         6'd0);   // empty list
    issue_cmd(OP_REMOVE, 32'h0,         6'd63);
    issue_cmd(OP_NOP,    32'hFFFF_FFFF, 6'd63);
    issue_cmd(OP_ADD,    32'd7,         6'd0);
    issue_cmd(OP_ADD,    32'd2,         6'd0);
    issue_cmd(OP_ADD,    32'd9,         6'd0);
    issue_cmd(OP_ADD,    32'd7,         6'd0);
    issue_cmd(OP_READ,   32'h0,         6'd3);
    issue_cmd(OP_READ,   32'h0,         6'd4);   // one past the end
    issue_cmd(OP_REMOVE, 32'h0,         6'd3);
    issue_cmd(OP_ADD,    32'h0,         6'd0);
    issue_cmd(OP_ADD,    32'hFFFF_FFFF, 6'd0);
    issue_cmd(OP_READ,   32'h0,         6'd4);
    settle();

    // ordered insert into unordered contents, duplicates barred
    write_regs(1'b1, 1'b0);
    issue_cmd(OP_ADD,    32'd5,         6'd0);
    issue_cmd(OP_ADD,    32'h0,         6'd0);
    issue_cmd(OP_ADD,    32'hFFFF_FFFF, 6'd0);
    issue_cmd(OP_ADD,    32'd1,         6'd0);
    issue_cmd(OP_READ,   32'h0,         6'd0);
    issue_cmd(OP_REMOVE, 32'h0,         6'd0);
    issue_cmd(OP_READ,   32'h0,         6'd0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_regs(phase_sorted[ph], phase_dups[ph]);
      calm = (ph == 3);
      run_phase(PHASE_CMDS);
    end
    calm = 1'b0;
    settle();

    $display("Covered %0d commands and %0d result words over all four mode settings.",
             shadow.n_cmds, shadow.n_results);
    $display("Statuses seen: %0d duplicate drops, %0d list-full, %0d out-of-range.",
             shadow.n_dup, shadow.n_full, shadow.n_range);
    if (shadow.errors == 0 && shadow.outstanding() == 0)
      $display("** sorted_set_list_top: PASSED **");
    else
      $display("** sorted_set_list_top: FAILED **");
    $finish;
  end

endmodule
